// File: src/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks a property at every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/spq_pkg.sv
package spq_pkg;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } opcode_e;

  // Status codes carried in the result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FEW   = 2'd3
  } status_e;

  // Rank of the entry that a peek returns, counted from the largest.
  localparam int unsigned PeekRank = 3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [3:0]         entries_held;
    logic               queue_empty;
  } out_word_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic signed [31:0] value;
  } spq_ctl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic               valid;
    logic               keeps;
    logic signed [31:0] data;
  } spq_link_t;

endpackage

// File: src/spq_cell.sv
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_ctl_t  ctl_i,
  input  spq_pkg::spq_link_t prev_i,
  input  spq_pkg::spq_link_t next_i,
  output spq_pkg::spq_link_t link_o
);
  import spq_pkg::*;

  logic               valid_q, valid_d;
  logic signed [31:0] data_q, data_d;
  logic               keeps;

  // A cell holds its entry on a push when the entry is strictly larger.
  assign keeps = valid_q && ($signed(data_q) > $signed(ctl_i.value));

  // Cells are ordered largest first, so a push shifts toward the tail
  // and a pop shifts toward the head.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.push) begin
      if (!keeps) begin
        if (prev_i.keeps) begin
          valid_d = 1'b1;
          data_d  = ctl_i.value;
        end else begin
          valid_d = prev_i.valid;
          data_d  = prev_i.data;
        end
      end
    end else if (ctl_i.pop) begin
      valid_d = next_i.valid;
      data_d  = next_i.data;
    end
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry value, meaningful only while valid.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.keeps = keeps;
  assign link_o.data  = data_q;

endmodule

// File: src/sorted_priority_queue.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
// A result word is registered as its input word is taken.
// Throughput: one word per cycle while no waiting result is held back; every cell compares and shifts in parallel.
// A waiting result does not block the next input if the output is taken that cycle.
// Reset clears the cell occupancy flags, the entry count and the output valid flag.
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spq_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spq_pkg::out_word_t  out_word_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                in_fire;
  logic [CntW-1:0]     count_q, count_d;
  logic                full, empty;
  logic                out_valid_q;
  out_word_t           out_word_q, out_word_d;
  spq_ctl_t            ctl;
  spq_link_t           link [CAPACITY];
  spq_link_t           head_link, tail_link;
  logic [CAPACITY-1:0] valid_vec, valid_inc;
  logic [CntW+3:0]     count_ext;
  status_e             status;
  logic signed [31:0]  result;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full  = (count_q == CntW'(CAPACITY));
  assign empty = (count_q == '0);

  // Decode the operation and drive the cell command.
  always_comb begin
    ctl.push  = 1'b0;
    ctl.pop   = 1'b0;
    ctl.value = in_word_i.item_value;
    status    = ST_OK;
    result    = '0;
    count_d   = count_q;
    case (in_word_i.opcode)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.push = in_fire;
          count_d  = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctl.pop = in_fire;
          result  = link[0].data;
          count_d = count_q - 1'b1;
        end
      end
      OP_PEEK: begin
        if (!link[PeekRank-1].valid) begin
          status = ST_FEW;
        end else begin
          result = link[PeekRank-1].data;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // The head sees a neighbor that always keeps, so the first cell that does not
  // keep its entry takes the pushed value; the tail shifts in nothing.
  assign head_link = '{valid: 1'b1, keeps: 1'b1, data: '0};
  assign tail_link = '{valid: 1'b0, keeps: 1'b0, data: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_link_t prev_link, next_link;
    if (i == 0) begin : g_head
      assign prev_link = head_link;
    end else begin : g_mid_prev
      assign prev_link = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = tail_link;
    end else begin : g_mid_next
      assign next_link = link[i+1];
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (prev_link),
      .next_i (next_link),
      .link_o (link[i])
    );
    assign valid_vec[i] = link[i].valid;
  end

  // Result word assembly.
  assign count_ext = {4'b0000, count_d};
  always_comb begin
    out_word_d.result_value = result;
    out_word_d.status       = status;
    out_word_d.entries_held = count_ext[3:0];
    out_word_d.queue_empty  = (count_d == '0);
  end

  // Entry count and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Occupied cells form a contiguous run from the head.
  assign valid_inc = valid_vec + CAPACITY'(1);

  `SPQ_ASSERT(a_count_matches_cells, $countones(valid_vec) == count_q, "count differs from cells")
  `SPQ_ASSERT(a_cells_contiguous, (valid_vec & valid_inc) == '0, "occupied cells have a gap")
  `SPQ_ASSERT(a_head_sorted, valid_vec[1] |-> ($signed(link[0].data) >= $signed(link[1].data)), "head out of order")
  `SPQ_ASSERT(a_pop_decrements, in_fire && (in_word_i.opcode == OP_POP) && !empty |=> count_q == $past(count_q) - 1'b1, "pop did not decrement count")
  `SPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && (count_q == '0), "not idle in reset")

endmodule
